// ----- design/srfd_pkg.sv -----
// ----------------------------------------------------------------------------
// srfd_pkg: shared types and constants of the serial radio frame deframer
// Frame bytes, response ids, result kinds and the result beat layout.
// ----------------------------------------------------------------------------
package srfd_pkg;

  localparam int unsigned MaxPayloadDef = 127;

  localparam logic [7:0] StartA     = 8'h7A;
  localparam logic [7:0] StartB     = 8'h62;
  localparam logic [7:0] IdRecvData = 8'h8B;

  typedef enum logic [2:0] {
    KindData    = 3'd0,
    KindMatch   = 3'd1,
    KindUnmatch = 3'd2,
    KindClosed  = 3'd3,
    KindFraming = 3'd4,
    KindReject  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] frame_id;
    logic [7:0] param_value;
    logic [7:0] payload_byte;
    logic [6:0] payload_index;
    logic [7:0] frame_length;
    logic       frame_end;
  } result_t;

  function automatic logic accepted_id(logic [7:0] id);
    logic ok;
    case (id) inside
      8'h81, 8'h82, 8'h84, 8'h85, 8'h89, 8'h8B, 8'h8D, 8'h8F, 8'h90, 8'h91: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ----- design/srfd_in_if.sv -----
// ----------------------------------------------------------------------------
// srfd_in_if: input item channel
// Valid/ready channel carrying one received byte or one issued command id.
// ----------------------------------------------------------------------------
interface srfd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;
  logic [7:0] command_id;

  modport source (output valid, operation, rx_byte, command_id, input ready);
  modport sink   (input valid, operation, rx_byte, command_id, output ready);
endinterface

// ----- design/srfd_out_if.sv -----
// ----------------------------------------------------------------------------
// srfd_out_if: result channel
// Valid/ready channel carrying one deframer result beat.
// ----------------------------------------------------------------------------
interface srfd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] frame_id;
  logic [7:0] param_value;
  logic [7:0] payload_byte;
  logic [6:0] payload_index;
  logic [7:0] frame_length;
  logic       frame_end;

  modport source (output valid, kind, frame_id, param_value, payload_byte,
                  payload_index, frame_length, frame_end, input ready);
  modport sink   (input valid, kind, frame_id, param_value, payload_byte,
                  payload_index, frame_length, frame_end, output ready);
endinterface

// ----- design/serial_radio_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// serial_radio_frame_deframer: radio firmware link frame parser
// Each result beat is decoded combinationally and registered in the output buffer.
// Throughput: one input beat per cycle while the output buffer is not full.
// Input ready drops only while both result entries are occupied.
// Reset clears the parse state, the pending command and link_open.
// ----------------------------------------------------------------------------
module serial_radio_frame_deframer #(
  parameter int unsigned MaxPayload = srfd_pkg::MaxPayloadDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  srfd_in_if.sink    item_i,
  srfd_out_if.source result_o
);
  import srfd_pkg::*;

  logic    link_open_q;
  logic    accept;
  logic    res_valid;
  logic    full;
  result_t res;
  result_t head;

  assign item_i.ready = !full;
  assign accept       = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_open_q <= 1'b0;
    end else if (cfg_we_i) begin
      link_open_q <= cfg_wdata_i;
    end
  end

  srfd_parser #(.MaxPayload(MaxPayload)) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (item_i.operation),
    .rx_byte_i    (item_i.rx_byte),
    .command_id_i (item_i.command_id),
    .link_open_i  (link_open_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  srfd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && res_valid),
    .data_i  (res),
    .full_o  (full),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .data_o  (head)
  );

  assign result_o.kind          = head.kind;
  assign result_o.frame_id      = head.frame_id;
  assign result_o.param_value   = head.param_value;
  assign result_o.payload_byte  = head.payload_byte;
  assign result_o.payload_index = head.payload_index;
  assign result_o.frame_length  = head.frame_length;
  assign result_o.frame_end     = head.frame_end;

endmodule

// ----- design/srfd_parser.sv -----
// ----------------------------------------------------------------------------
// srfd_parser: frame parser state and result decode
// Updates the parse state on each accepted beat and decodes its result.
// ----------------------------------------------------------------------------
module srfd_parser #(
  parameter int unsigned MaxPayload = srfd_pkg::MaxPayloadDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      operation_i,
  input  logic [7:0]                rx_byte_i,
  input  logic [7:0]                command_id_i,
  input  logic                      link_open_i,
  output logic                      res_valid_o,
  output srfd_pkg::result_t         res_o
);
  import srfd_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPayload + 1);

  typedef enum logic [2:0] {
    PhStart1 = 3'd0,
    PhStart2 = 3'd1,
    PhId     = 3'd2,
    PhParam1 = 3'd3,
    PhLength = 3'd4,
    PhData   = 3'd5
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      cur_id_q, cur_id_d;
  logic [7:0]      param_q, param_d;
  logic [7:0]      len_q, len_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      pend_q, pend_d;

  logic [8:0]      cnt_inc;
  logic            fits;

  assign cnt_inc = 9'(cnt_q) + 9'd1;
  assign fits    = (cur_id_q == IdRecvData) ||
                   (accepted_id(cur_id_q) && pend_q == {1'b0, cur_id_q[6:0]});

  always_comb begin
    phase_d     = phase_q;
    cur_id_d    = cur_id_q;
    param_d     = param_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (operation_i) begin
      if (pend_q != 8'd0) begin
        phase_d = PhStart1;
        cur_id_d = '0; param_d = '0; len_d = '0; cnt_d = '0; pend_d = '0;
        res_valid_o       = 1'b1;
        res_o.kind        = KindReject;
        res_o.frame_id    = command_id_i;
        res_o.param_value = pend_q;
      end else begin
        pend_d = command_id_i;
      end
    end else begin
      // drop to the idle state unless a case below advances
      phase_d = PhStart1;
      cur_id_d = '0; param_d = '0; len_d = '0; cnt_d = '0; pend_d = '0;
      case (phase_q)
        PhStart1: begin
          if (rx_byte_i == StartA) begin
            phase_d = PhStart2;
            cur_id_d = cur_id_q; param_d = param_q; len_d = len_q;
            cnt_d = cnt_q; pend_d = pend_q;
          end
        end
        PhStart2: begin
          if (rx_byte_i == StartB) begin
            phase_d = PhId;
            cur_id_d = cur_id_q; param_d = param_q; len_d = len_q;
            cnt_d = cnt_q; pend_d = pend_q;
          end else begin
            res_valid_o     = 1'b1;
            res_o.kind      = KindFraming;
            res_o.frame_end = 1'b1;
          end
        end
        PhId: begin
          if (accepted_id(rx_byte_i)) begin
            phase_d = PhParam1;
            cur_id_d = rx_byte_i; param_d = param_q; len_d = len_q;
            cnt_d = cnt_q; pend_d = pend_q;
          end else begin
            res_valid_o     = 1'b1;
            res_o.kind      = KindFraming;
            res_o.frame_id  = rx_byte_i;
            res_o.frame_end = 1'b1;
          end
        end
        PhParam1: begin
          if (cur_id_q == IdRecvData) begin
            phase_d = PhLength;
            cur_id_d = cur_id_q; param_d = rx_byte_i; len_d = len_q;
            cnt_d = cnt_q; pend_d = pend_q;
          end else begin
            res_valid_o       = 1'b1;
            res_o.kind        = !fits ? KindUnmatch :
                                (!link_open_i ? KindClosed : KindMatch);
            res_o.frame_id    = cur_id_q;
            res_o.param_value = rx_byte_i;
            res_o.frame_end   = 1'b1;
          end
        end
        PhLength: begin
          phase_d = PhData;
          cur_id_d = cur_id_q; param_d = param_q; len_d = rx_byte_i;
          cnt_d = cnt_q; pend_d = pend_q;
        end
        PhData: begin
          res_valid_o = 1'b1;
          if (cnt_q < CntW'(MaxPayload) && {1'b0, len_q} <= 9'(MaxPayload)) begin
            res_o.frame_id      = IdRecvData;
            res_o.param_value   = param_q;
            res_o.payload_byte  = rx_byte_i;
            res_o.payload_index = 7'(cnt_q);
            res_o.frame_length  = len_q;
            if (cnt_inc == {1'b0, len_q}) begin
              res_o.kind      = link_open_i ? KindData : KindClosed;
              res_o.frame_end = 1'b1;
            end else begin
              res_o.kind = KindData;
              phase_d = PhData;
              cur_id_d = cur_id_q; param_d = param_q; len_d = len_q;
              cnt_d = CntW'(cnt_inc); pend_d = pend_q;
            end
          end else begin
            res_o.kind      = KindFraming;
            res_o.frame_id  = IdRecvData;
            res_o.frame_end = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhStart1;
      cur_id_q <= '0;
      param_q  <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      pend_q   <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      cur_id_q <= cur_id_d;
      param_q  <= param_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
    end
  end

endmodule

// ----- design/srfd_out_buf.sv -----
// ----------------------------------------------------------------------------
// srfd_out_buf: result register with skid entry
// Two-entry buffer that registers result beats and decouples the two sides.
// ----------------------------------------------------------------------------
module srfd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  srfd_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output srfd_pkg::result_t data_o
);
  import srfd_pkg::*;

  result_t    head_q, skid_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      head_q <= (push_i && cnt_q == 2'd1) ? data_i : skid_q;
    end else if (push_i && cnt_q == 2'd0) begin
      head_q <= data_i;
    end
    if (push_i && !pop && cnt_q == 2'd1) begin
      skid_q <= data_i;
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for serial_radio_frame_deframer
// Feeds directed and random byte streams and command beats over the valid/ready
// item channel, predicts each result beat in a scoreboard that tracks the parse
// state, pending command and link_open, and checks every result beat in order
// under random sender bursts, receiver stalls and link_open changes.
// ----------------------------------------------------------------------------
module tb;
  import srfd_pkg::*;

  typedef enum logic [2:0] {
    PhStart1, PhStart2, PhId, PhParam, PhLength, PhData
  } parse_phase_e;

  typedef enum logic [1:0] {RxFlow, RxCoin, RxSparse, RxToggle} rx_mode_e;

  localparam logic [7:0] ReplyIds [0:8] = '{8'h81, 8'h82, 8'h84, 8'h85, 8'h89,
                                            8'h8D, 8'h8F, 8'h90, 8'h91};

  class frame_scoreboard;
    bit           link_open;
    parse_phase_e phase;
    logic [7:0]   cur_id;
    logic [7:0]   link_quality;
    logic [7:0]   decl_len;
    int           count;
    logic [7:0]   pending;
    result_t      awaited[$];
    int           errors;

    function void clear_parser();
      phase        = PhStart1;
      cur_id       = '0;
      link_quality = '0;
      decl_len     = '0;
      count        = 0;
      pending      = '0;
    endfunction

    function bit id_known(logic [7:0] b);
      return b inside {8'h81, 8'h82, 8'h84, 8'h85, 8'h89, 8'h8B, 8'h8D, 8'h8F,
                       8'h90, 8'h91};
    endfunction

    function void push(kind_e k, logic [7:0] id, logic [7:0] pv, logic [7:0] pb,
                       logic [6:0] pi, logic [7:0] fl, logic fe);
      result_t r;
      r.kind          = k;
      r.frame_id      = id;
      r.param_value   = pv;
      r.payload_byte  = pb;
      r.payload_index = pi;
      r.frame_length  = fl;
      r.frame_end     = fe;
      awaited.push_back(r);
    endfunction

    function void note_item(bit op, logic [7:0] rx, logic [7:0] cmd);
      logic [7:0] id_now;
      logic [7:0] lq;
      logic [7:0] len;
      int         idx;
      kind_e      k;
      if (op) begin
        if (pending != 0) begin
          lq = pending;
          clear_parser();
          push(KindReject, cmd, lq, '0, '0, '0, 1'b0);
        end else begin
          pending = cmd;
        end
        return;
      end
      case (phase)
        PhStart1: begin
          if (rx == StartA) phase = PhStart2;
          else clear_parser();
        end
        PhStart2: begin
          if (rx == StartB) begin
            phase = PhId;
          end else begin
            clear_parser();
            push(KindFraming, '0, '0, '0, '0, '0, 1'b1);
          end
        end
        PhId: begin
          if (id_known(rx)) begin
            cur_id = rx;
            phase  = PhParam;
          end else begin
            clear_parser();
            push(KindFraming, rx, '0, '0, '0, '0, 1'b1);
          end
        end
        PhParam: begin
          link_quality = rx;
          if (cur_id == IdRecvData) begin
            phase = PhLength;
          end else begin
            id_now = cur_id;
            if (pending != {1'b0, id_now[6:0]}) k = KindUnmatch;
            else if (!link_open) k = KindClosed;
            else k = KindMatch;
            clear_parser();
            push(k, id_now, rx, '0, '0, '0, 1'b1);
          end
        end
        PhLength: begin
          decl_len = rx;
          phase    = PhData;
        end
        PhData: begin
          if (count < MaxPayloadDef && decl_len <= MaxPayloadDef) begin
            idx   = count;
            count = count + 1;
            lq    = link_quality;
            len   = decl_len;
            if (count == len) begin
              k = link_open ? KindData : KindClosed;
              clear_parser();
              push(k, IdRecvData, lq, rx, idx[6:0], len, 1'b1);
            end else begin
              push(KindData, IdRecvData, lq, rx, idx[6:0], len, 1'b0);
            end
          end else begin
            clear_parser();
            push(KindFraming, IdRecvData, '0, '0, '0, '0, 1'b1);
          end
        end
        default: clear_parser();
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d id %02h", got.kind,
                                  got.frame_id));
        return;
      end
      want = awaited.pop_front();
      compare_field("kind", 8'(got.kind), 8'(want.kind));
      compare_field("frame_id", got.frame_id, want.frame_id);
      compare_field("param_value", got.param_value, want.param_value);
      compare_field("payload_byte", got.payload_byte, want.payload_byte);
      compare_field("payload_index", 8'(got.payload_index), 8'(want.payload_index));
      compare_field("frame_length", got.frame_length, want.frame_length);
      compare_field("frame_end", 8'(got.frame_end), 8'(want.frame_end));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  srfd_in_if  item_if ();
  srfd_out_if res_if ();

  serial_radio_frame_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .result_o    (res_if)
  );

  frame_scoreboard sb = new;
  int burst_left;
  int beats;
  int noise_beats;
  bit hold_req;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Receiver: check each result beat, then pick the next ready value.
  initial begin
    result_t  got;
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    logic     rdy;
    res_if.ready = 1'b0;
    mode         = RxFlow;
    mode_left    = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        got.kind          = res_if.kind;
        got.frame_id      = res_if.frame_id;
        got.param_value   = res_if.param_value;
        got.payload_byte  = res_if.payload_byte;
        got.payload_index = res_if.payload_index;
        got.frame_length  = res_if.frame_length;
        got.frame_end     = res_if.frame_end;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          RxFlow:   rdy = 1'b1;
          RxCoin:   rdy = 1'($urandom_range(0, 1));
          RxSparse: rdy = ($urandom_range(0, 3) == 0);
          default:  rdy = ~res_if.ready;
        endcase
      end
      res_if.ready <= rdy;
    end
  end

  task automatic send_item(bit op, logic [7:0] rx, logic [7:0] cmd);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    item_if.valid      <= 1'b1;
    item_if.operation  <= op;
    item_if.rx_byte    <= rx;
    item_if.command_id <= cmd;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    sb.note_item(op, rx, cmd);
    beats++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(1'b0, b, 8'($urandom));
  endtask

  task automatic issue_cmd(logic [7:0] c);
    send_item(1'b1, 8'($urandom), c);
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_link(bit open);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= open;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    sb.link_open = open;
  endtask

  task automatic send_data_frame(logic [7:0] len);
    int n;
    send_byte(StartA);
    send_byte(StartB);
    send_byte(IdRecvData);
    send_byte(8'($urandom));
    send_byte(len);
    n = (len == 0) ? MaxPayloadDef + 1 : (len > MaxPayloadDef) ? 1 : len;
    repeat (n) send_byte(8'($urandom));
  endtask

  task automatic send_frame();
    logic [7:0] id;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      r = $urandom_range(0, 99);
      if (r < 80) send_data_frame(8'($urandom_range(1, 8)));
      else if (r < 88) send_data_frame(8'($urandom_range(9, 40)));
      else if (r < 92) send_data_frame(8'd127);
      else if (r < 95) send_data_frame(8'd0);
      else send_data_frame(8'($urandom_range(128, 255)));
    end else begin
      id = ReplyIds[$urandom_range(0, 8)];
      r  = $urandom_range(0, 99);
      if (r < 70) issue_cmd({1'b0, id[6:0]});
      else if (r < 85) issue_cmd(8'($urandom));
      send_byte(StartA);
      send_byte(StartB);
      if ($urandom_range(0, 9) == 0) issue_cmd(8'($urandom));
      send_byte(id);
      send_byte(8'($urandom));
    end
  endtask

  task automatic send_noise();
    int start;
    int n;
    start = beats;
    case ($urandom_range(0, 5))
      0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      1: issue_cmd(8'($urandom));
      2: begin
        send_byte(StartA);
        send_byte(8'($urandom));
      end
      3: begin
        send_byte(StartA);
        send_byte(StartB);
        send_byte(8'($urandom));
      end
      4: begin
        send_byte(StartA);
        send_byte(StartB);
        send_byte(ReplyIds[$urandom_range(0, 8)]);
      end
      default: begin
        n = $urandom_range(2, 8);
        send_byte(StartA);
        send_byte(StartB);
        send_byte(IdRecvData);
        send_byte(8'($urandom));
        send_byte(8'(n));
        repeat ($urandom_range(0, n - 1)) send_byte(8'($urandom));
      end
    endcase
    noise_beats += beats - start;
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = 1'b0;
    item_if.valid      = 1'b0;
    item_if.operation  = 1'b0;
    item_if.rx_byte    = '0;
    item_if.command_id = '0;
    burst_left         = 0;
    beats              = 0;
    noise_beats        = 0;
    hold_req           = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_link(1'b0);
    send_byte(8'hFF);
    send_byte(StartA);
    send_byte(8'hFF);
    send_byte(StartA);
    send_byte(StartB);
    send_byte(8'h80);
    issue_cmd(8'h01);
    send_byte(StartA);
    send_byte(StartB);
    send_byte(8'h81);
    send_byte(8'hFF);
    issue_cmd(8'h05);
    issue_cmd(8'hFF);
    send_byte(StartA);
    send_byte(StartB);
    send_byte(IdRecvData);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h00);
    drain();
    set_link(1'b1);
    issue_cmd(8'h02);
    send_byte(StartA);
    send_byte(StartB);
    send_byte(8'h82);
    send_byte(8'h00);
    send_byte(StartA);
    send_byte(StartB);
    send_byte(8'h90);
    send_byte(8'h11);

    for (int p = 0; p < 6; p++) begin
      drain();
      set_link(p % 2 == 0);
      if (p == 0) send_data_frame(8'd0);
      if (p == 1) begin
        hold_req = 1'b1;
        send_data_frame(8'd127);
      end
      while (beats - noise_beats < (p + 1) * 250) begin
        if ($urandom_range(0, 99) < 80) send_frame();
        else send_noise();
      end
    end
    drain();
    repeat (10) @(posedge clk_i);

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/srfd_pkg.sv
design/srfd_in_if.sv
design/srfd_out_if.sv
design/srfd_parser.sv
design/srfd_out_buf.sv
design/serial_radio_frame_deframer.sv
test/tb.sv
